FILE: sv/s2ok_pkg.sv
// Shared constants, types and table builder for the sRGB to OkLab converter.
`default_nettype none
package s2ok_pkg;

  localparam int CHANNEL_BITS_DEF  = 8;
  localparam int OUT_FRAC_BITS_DEF = 12;
  localparam int LIN_W  = 16;
  localparam int CBRT_STAGES = 16;
  localparam int LAB_COEF_W = 19;

  typedef logic [LIN_W-1:0] lin_t;

  localparam int unsigned TO_LMS [3][3] = '{
    '{27012, 35145,  3372},
    '{13884, 44612,  7039},
    '{ 5787, 18471, 41305}
  };

  localparam int TO_LAB [3][3] = '{
    '{ 13792,   52011,   -267},
    '{129630, -159160,  29530},
    '{  1698,   51300, -52997}
  };

  localparam longint unsigned Q30_ONE = 64'd1 << 30;

  function automatic longint unsigned mul_q30(longint unsigned a, longint unsigned b);
    return (a * b) >> 30;
  endfunction

  function automatic longint unsigned pow5_q30(longint unsigned y);
    longint unsigned sq;
    longint unsigned qu;
    sq = mul_q30(y, y);
    qu = mul_q30(sq, sq);
    return mul_q30(qu, y);
  endfunction

  // Restoring long division, used only while building the constant table.
  function automatic longint unsigned udiv64(longint unsigned n, longint unsigned d);
    longint unsigned q;
    longint unsigned rem;
    q   = 64'd0;
    rem = 64'd0;
    for (int k = 63; k >= 0; k--) begin
      rem = (rem << 1) | ((n >> k) & 64'd1);
      if (rem >= d) begin
        rem = rem - d;
        q   = q | (64'd1 << k);
      end
    end
    return q;
  endfunction

  // sRGB transfer decode of one code, evaluated at elaboration only.
  function automatic lin_t decode_entry(longint unsigned v, int cbits);
    longint unsigned maxv;
    longint unsigned res;
    longint unsigned t;
    longint unsigned u;
    longint unsigned y;
    longint unsigned cand;
    maxv = (64'd1 << cbits) - 64'd1;
    if (v * 64'd100000 <= 64'd4045 * maxv) begin
      res = udiv64(64'd2 * v * 64'd6553600 + 64'd1292 * maxv, 64'd2 * 64'd1292 * maxv);
    end else begin
      t = udiv64((v * 64'd1000 + 64'd55 * maxv) << 30, 64'd1055 * maxv);
      if (t > Q30_ONE) t = Q30_ONE;
      u = mul_q30(t, t);
      y = 64'd0;
      for (int b = 30; b >= 0; b--) begin
        cand = y | (64'd1 << b);
        if (cand <= Q30_ONE && pow5_q30(cand) <= u) y = cand;
      end
      res = (mul_q30(u, y) + (64'd1 << 13)) >> 14;
    end
    if (res > 64'd65535) res = 64'd65535;
    return res[LIN_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: sv/s2ok_cbrt_lane.sv
// Pipelined cube root lane: floor(cbrt(x * 2^32)), one result bit per stage.
`default_nettype none
module s2ok_cbrt_lane (
  input  wire logic                               clk,
  input  wire logic [s2ok_pkg::CBRT_STAGES-1:0]   adv,
  input  wire logic [s2ok_pkg::LIN_W-1:0]         x,
  output logic      [s2ok_pkg::LIN_W-1:0]         root
);
  localparam int N  = s2ok_pkg::CBRT_STAGES;
  localparam int RW = s2ok_pkg::LIN_W;
  localparam int CW = 3 * RW + 2;

  logic [RW-1:0]   r_r   [N];
  logic [2*RW-1:0] s_r   [N];
  logic [CW-1:0]   y_r   [N];
  logic [CW-1:0]   tgt_r [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int B = N - 1 - k;
    logic [RW-1:0]   r_in;
    logic [2*RW-1:0] s_in;
    logic [CW-1:0]   y_in;
    logic [CW-1:0]   t_in;
    logic [CW-1:0]   c3;
    logic [2*RW-1:0] s_new;

    if (k == 0) begin : g_first
      assign r_in = '0;
      assign s_in = '0;
      assign y_in = '0;
      assign t_in = {2'b00, x, {(2*RW){1'b0}}};
    end else begin : g_next
      assign r_in = r_r[k-1];
      assign s_in = s_r[k-1];
      assign y_in = y_r[k-1];
      assign t_in = tgt_r[k-1];
    end

    // (r + 2^B)^3 = r^3 + 3 r^2 2^B + 3 r 2^2B + 2^3B
    assign c3 = y_in
              + ((CW'(s_in) + (CW'(s_in) << 1)) << B)
              + ((CW'(r_in) + (CW'(r_in) << 1)) << (2 * B))
              + (CW'(1) << (3 * B));
    assign s_new = s_in + ((2*RW)'(r_in) << (B + 1)) + ((2*RW)'(1) << (2 * B));

    always_ff @(posedge clk) begin
      if (adv[k]) begin
        tgt_r[k] <= t_in;
        if (c3 <= t_in) begin
          r_r[k] <= r_in | (RW'(1) << B);
          s_r[k] <= s_new;
          y_r[k] <= c3;
        end else begin
          r_r[k] <= r_in;
          s_r[k] <= s_in;
          y_r[k] <= y_in;
        end
      end
    end
  end

  assign root = r_r[N-1];
endmodule
`default_nettype wire

FILE: sv/s2ok_lab_merge.sv
// Merge of the three cube-root lanes into OkLab L, a, b with rounding and saturation.
`default_nettype none
module s2ok_lab_merge #(
  parameter int OUT_FRAC_BITS = s2ok_pkg::OUT_FRAC_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic [1:0]                      adv,
  input  wire logic [s2ok_pkg::LIN_W-1:0]      cr [3],
  output logic      [OUT_FRAC_BITS-1:0]        lightness,
  output logic signed [OUT_FRAC_BITS-1:0]      green_red_axis,
  output logic signed [OUT_FRAC_BITS-1:0]      blue_yellow_axis
);
  localparam int AW = 38;
  localparam int SH = 32 - OUT_FRAC_BITS;
  localparam logic signed [AW-1:0] LMAX = AW'((64'sd1 <<< OUT_FRAC_BITS) - 1);
  localparam logic signed [AW-1:0] AMAX = AW'((64'sd1 <<< (OUT_FRAC_BITS - 1)) - 1);
  localparam logic signed [AW-1:0] AMIN = AW'(-(64'sd1 <<< (OUT_FRAC_BITS - 1)));
  localparam logic signed [AW-1:0] HALF = AW'(64'sd1 <<< (SH - 1));

  logic signed [AW-1:0] acc_nxt [3];
  logic signed [AW-1:0] acc_r   [3];
  logic signed [AW-1:0] rnd     [3];
  logic signed [AW-1:0] sat     [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc_nxt[i] = '0;
      for (int j = 0; j < 3; j++) begin
        acc_nxt[i] = acc_nxt[i]
          + AW'($signed(s2ok_pkg::LAB_COEF_W'(s2ok_pkg::TO_LAB[i][j]))
                * $signed({1'b0, cr[j]}));
      end
      rnd[i] = (acc_r[i] + HALF) >>> SH;
    end
    sat[0] = (rnd[0] < 0) ? '0 : ((rnd[0] > LMAX) ? LMAX : rnd[0]);
    for (int i = 1; i < 3; i++) begin
      sat[i] = (rnd[i] > AMAX) ? AMAX : ((rnd[i] < AMIN) ? AMIN : rnd[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      acc_r <= acc_nxt;
    end
    if (adv[1]) begin
      lightness        <= sat[0][OUT_FRAC_BITS-1:0];
      green_red_axis   <= sat[1][OUT_FRAC_BITS-1:0];
      blue_yellow_axis <= sat[2][OUT_FRAC_BITS-1:0];
    end
  end
endmodule
`default_nettype wire

FILE: sv/srgb_to_oklab_converter.sv
// Top level: sRGB pixel in, OkLab L/a/b out, fully pipelined.
// Throughput: one pixel per cycle while the output is not stalled; each of the 20
//   stages takes a new item every cycle, and a stalled result holds only the full
//   stages behind it.
// Reset (rst_n low, synchronous) clears all stage valid bits; data holds none.
`default_nettype none
module srgb_to_oklab_converter #(
  parameter int CHANNEL_BITS  = s2ok_pkg::CHANNEL_BITS_DEF,
  parameter int OUT_FRAC_BITS = s2ok_pkg::OUT_FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [CHANNEL_BITS-1:0]       in_red_in,
  input  wire logic [CHANNEL_BITS-1:0]       in_green_in,
  input  wire logic [CHANNEL_BITS-1:0]       in_blue_in,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [OUT_FRAC_BITS-1:0]           out_lightness,
  output logic signed [OUT_FRAC_BITS-1:0]    out_green_red_axis,
  output logic signed [OUT_FRAC_BITS-1:0]    out_blue_yellow_axis
);
  localparam int NCB   = s2ok_pkg::CBRT_STAGES;
  localparam int NST   = NCB + 4;   // decode, LMS, cube root stages, Lab acc, output
  localparam int LW    = s2ok_pkg::LIN_W;
  localparam int DEPTH = 2 ** CHANNEL_BITS;

  typedef logic [LW-1:0] lut_t [DEPTH];

  function automatic lut_t build_lut();
    lut_t t;
    for (int i = 0; i < DEPTH; i++) begin
      t[i] = s2ok_pkg::decode_entry(longint'(i), CHANNEL_BITS);
    end
    return t;
  endfunction

  // Gamma decode table, built at elaboration.
  localparam lut_t DECODE_LUT = build_lut();

  // Stage valid bits and the advance chain.
  logic [NST-1:0] vld_r;
  logic [NST-1:0] vld_nxt;
  logic [NST:0]   rdy;

  always_comb begin
    rdy[NST] = !out_stall;
    for (int i = NST - 1; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
    for (int i = 0; i < NST; i++) begin
      if (rdy[i]) begin
        vld_nxt[i] = (i == 0) ? in_valid : vld_r[i-1];
      end else begin
        vld_nxt[i] = vld_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = vld_r[NST-1];

  // Stage 0: per-channel gamma decode.
  logic [LW-1:0] lin_r [3];
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      lin_r[0] <= DECODE_LUT[in_red_in];
      lin_r[1] <= DECODE_LUT[in_green_in];
      lin_r[2] <= DECODE_LUT[in_blue_in];
    end
  end

  // Stage 1: linear RGB to LMS, rounded and clamped to one.
  logic [34:0]   lms_acc [3];
  logic [18:0]   lms_q   [3];
  logic [LW-1:0] lms_r   [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lms_acc[i] = '0;
      for (int j = 0; j < 3; j++) begin
        lms_acc[i] = lms_acc[i] + 35'(17'(s2ok_pkg::TO_LMS[i][j]) * 33'(lin_r[j]));
      end
      lms_q[i] = 19'((lms_acc[i] + 35'd32768) >> 16);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int i = 0; i < 3; i++) begin
        lms_r[i] <= (lms_q[i] > 19'd65535) ? {LW{1'b1}} : lms_q[i][LW-1:0];
      end
    end
  end

  // Stages 2..17: one cube-root lane per LMS component.
  logic [LW-1:0] cr [3];
  for (genvar i = 0; i < 3; i++) begin : g_lane
    s2ok_cbrt_lane u_lane (
      .clk  (clk),
      .adv  (rdy[NCB+1:2]),
      .x    (lms_r[i]),
      .root (cr[i])
    );
  end

  // Stages 18..19: combine lanes into L, a, b.
  s2ok_lab_merge #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_merge (
    .clk              (clk),
    .adv              (rdy[NST-1:NST-2]),
    .cr               (cr),
    .lightness        (out_lightness),
    .green_red_axis   (out_green_red_axis),
    .blue_yellow_axis (out_blue_yellow_axis)
  );
endmodule
`default_nettype wire

FILE: sv/s2ok_checker.sv
// Port-level checks for the converter, bound to the top level.
`default_nettype none
module s2ok_checker #(
  parameter int CHANNEL_BITS  = s2ok_pkg::CHANNEL_BITS_DEF,
  parameter int OUT_FRAC_BITS = s2ok_pkg::OUT_FRAC_BITS_DEF
) (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_stall,
  input wire logic [CHANNEL_BITS-1:0]     in_red_in,
  input wire logic [CHANNEL_BITS-1:0]     in_green_in,
  input wire logic [CHANNEL_BITS-1:0]     in_blue_in,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [OUT_FRAC_BITS-1:0]    out_lightness,
  input wire logic [OUT_FRAC_BITS-1:0]    out_green_red_axis,
  input wire logic [OUT_FRAC_BITS-1:0]    out_blue_yellow_axis
);
  // Pipeline is empty right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // Input backs up only when the pipeline is full and the output is stalled.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled with room in pipeline");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_lightness)
      && $stable(out_green_red_axis) && $stable(out_blue_yellow_axis)))
    else $error("stalled result changed");
endmodule

bind srgb_to_oklab_converter s2ok_checker #(
  .CHANNEL_BITS  (CHANNEL_BITS),
  .OUT_FRAC_BITS (OUT_FRAC_BITS)
) u_s2ok_checker (.*);
`default_nettype wire
